[design/hsf_pkg.sv]
// ----------------------------------------------------------------------------
// hsf_pkg
// Shared types and constants for the heater supervision state machine.
// ----------------------------------------------------------------------------
package hsf_pkg;

	// Supervision modes, one-hot.
	typedef enum logic [3:0] {
		MODE_IDLE  = 4'b0001,
		MODE_RAMP  = 4'b0010,
		MODE_TRACK = 4'b0100,
		MODE_FAULT = 4'b1000
	} mode_t;

	// State codes as reported on the result channel.
	localparam logic [1:0] CODE_IDLE  = 2'd0;
	localparam logic [1:0] CODE_RAMP  = 2'd1;
	localparam logic [1:0] CODE_TRACK = 2'd2;
	localparam logic [1:0] CODE_FAULT = 2'd3;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIP_TICKS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IN_BAND       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IN_BAND_TICKS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_BAND      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_MARGIN  = 3'd5;

	localparam int unsigned DATA_W = 16;

	// Register reset values.
	localparam logic [DATA_W-1:0] RST_HIGH_LIMIT    = 16'd1600;
	localparam logic [DATA_W-1:0] RST_TRIP_TICKS    = 16'd10;
	localparam logic [DATA_W-1:0] RST_IN_BAND       = 16'd32;
	localparam logic [DATA_W-1:0] RST_IN_BAND_TICKS = 16'd50;
	localparam logic [DATA_W-1:0] RST_OUT_BAND      = 16'd80;
	localparam logic [DATA_W-1:0] RST_RESET_MARGIN  = 16'd160;

	// Near-limit alarm offset: 5 degrees in 1/16 degree units.
	localparam logic [DATA_W:0] NEAR_OFFSET = 17'd80;

endpackage

[design/heater_supervision_fsm_unit.sv]
// ----------------------------------------------------------------------------
// heater_supervision_fsm_unit
// Heater supervision: idle, ramp, track and latched overtemperature fault.
// ----------------------------------------------------------------------------
// A transaction is registered in the input stage and then in the result register;
// its result is presented straight from the result register.
// Throughput: one transaction per cycle unless stalled; the state update is a single
// pass of compares and counter increments between the input and result registers.
// The input stalls only while both registers are full and the result is held.
// Reset: arst_n clears the state, the counters, the alarm latch and both
// pipeline stages, and loads the configuration registers with their defaults.
module heater_supervision_fsm_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [hsf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hsf_pkg::DATA_W-1:0]          cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                enable,
	input  logic                                fault_clear,
	input  logic signed [hsf_pkg::DATA_W-1:0]   setpoint,
	input  logic signed [hsf_pkg::DATA_W-1:0]   actual,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          state_code,
	output logic                                near_limit,
	output logic                                overtemp,
	output logic                                heater_on
);

	localparam int unsigned W = hsf_pkg::DATA_W;
	localparam logic [W-1:0] CNT_MAX = '1;

	function automatic logic [W-1:0] sat_inc(input logic [W-1:0] c);
		return (c == CNT_MAX) ? c : c + W'(1);
	endfunction

	// Configuration registers.
	logic [W-1:0] high_limit_q, trip_ticks_q, in_band_q;
	logic [W-1:0] in_band_ticks_q, out_band_q, reset_margin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_limit_q    <= hsf_pkg::RST_HIGH_LIMIT;
			trip_ticks_q    <= hsf_pkg::RST_TRIP_TICKS;
			in_band_q       <= hsf_pkg::RST_IN_BAND;
			in_band_ticks_q <= hsf_pkg::RST_IN_BAND_TICKS;
			out_band_q      <= hsf_pkg::RST_OUT_BAND;
			reset_margin_q  <= hsf_pkg::RST_RESET_MARGIN;
		end else if (cfg_we) begin
			case (cfg_index)
				hsf_pkg::REG_HIGH_LIMIT:    high_limit_q    <= cfg_wdata;
				hsf_pkg::REG_TRIP_TICKS:    trip_ticks_q    <= cfg_wdata;
				hsf_pkg::REG_IN_BAND:       in_band_q       <= cfg_wdata;
				hsf_pkg::REG_IN_BAND_TICKS: in_band_ticks_q <= cfg_wdata;
				hsf_pkg::REG_OUT_BAND:      out_band_q      <= cfg_wdata;
				hsf_pkg::REG_RESET_MARGIN:  reset_margin_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input stage.
	logic         valid_s1;
	logic         enable_s1, clear_s1;
	logic [W-1:0] setpoint_s1, actual_s1;
	logic         advance;

	// The result register moves whenever it is empty or being taken.
	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			enable_s1   <= enable;
			clear_s1    <= fault_clear;
			setpoint_s1 <= setpoint;
			actual_s1   <= actual;
		end
	end

	// Supervision state.
	hsf_pkg::mode_t mode_q, mode_d;
	logic [W-1:0]   band_count_q, band_count_d;
	logic [W-1:0]   trip_count_q, trip_count_d;
	logic           latch_q, latch_d;
	logic           last_clear_q;

	logic signed [W:0]   act_x, diff, near_thr;
	logic [W:0]          err;
	logic signed [W+1:0] clear_thr;
	logic                over, near_now, trip, in_band_now, clear_ok;
	logic [W-1:0]        trip_inc, band_inc;

	always_comb begin
		act_x     = {actual_s1[W-1], actual_s1};
		diff      = {setpoint_s1[W-1], setpoint_s1} - act_x;
		err       = diff[W] ? (W+1)'(-diff) : diff;
		near_thr  = {high_limit_q[W-1], high_limit_q} - hsf_pkg::NEAR_OFFSET;
		clear_thr = {{2{high_limit_q[W-1]}}, high_limit_q} - {2'b00, reset_margin_q};

		over        = $signed(actual_s1) > $signed(high_limit_q);
		near_now    = act_x > near_thr;
		in_band_now = err <= {1'b0, in_band_q};
		clear_ok    = clear_s1 && !last_clear_q && ($signed({act_x[W], act_x}) < clear_thr);

		trip_inc = sat_inc(trip_count_q);
		band_inc = sat_inc(band_count_q);
		trip     = 1'b0;

		mode_d       = mode_q;
		band_count_d = band_count_q;
		trip_count_d = trip_count_q;
		latch_d      = latch_q;

		if (mode_q != hsf_pkg::MODE_FAULT) begin
			trip_count_d = over ? trip_inc : '0;
			trip         = over && (trip_inc >= trip_ticks_q);
		end

		// A trip lands in fault; the clear rule cannot hold while over the limit.
		if (trip) begin
			latch_d      = 1'b1;
			mode_d       = hsf_pkg::MODE_FAULT;
			band_count_d = '0;
		end else begin
			case (mode_q)
				hsf_pkg::MODE_IDLE: begin
					if (enable_s1) begin
						mode_d       = hsf_pkg::MODE_RAMP;
						band_count_d = '0;
					end
				end
				hsf_pkg::MODE_RAMP: begin
					if (!enable_s1) begin
						mode_d       = hsf_pkg::MODE_IDLE;
						band_count_d = '0;
					end else if (in_band_now) begin
						if (band_inc >= in_band_ticks_q) begin
							mode_d       = hsf_pkg::MODE_TRACK;
							band_count_d = '0;
						end else begin
							band_count_d = band_inc;
						end
					end else begin
						band_count_d = '0;
					end
				end
				hsf_pkg::MODE_TRACK: begin
					if (!enable_s1) begin
						mode_d       = hsf_pkg::MODE_IDLE;
						band_count_d = '0;
					end else if (err > {1'b0, out_band_q}) begin
						mode_d       = hsf_pkg::MODE_RAMP;
						band_count_d = '0;
					end
				end
				default: begin
					if (clear_ok) begin
						latch_d      = 1'b0;
						trip_count_d = '0;
						mode_d       = hsf_pkg::MODE_IDLE;
						band_count_d = '0;
					end
				end
			endcase
		end
	end

	logic step;
	assign step = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= hsf_pkg::MODE_IDLE;
			band_count_q <= '0;
			trip_count_q <= '0;
			latch_q      <= 1'b0;
			last_clear_q <= 1'b0;
		end else if (step) begin
			mode_q       <= mode_d;
			band_count_q <= band_count_d;
			trip_count_q <= trip_count_d;
			latch_q      <= latch_d;
			last_clear_q <= clear_s1;
		end
	end

	// Result stage.
	logic       valid_s2;
	logic [1:0] code_s2;
	logic       near_s2, overtemp_s2, heater_s2;
	logic [1:0] code_d;

	always_comb begin
		case (mode_d)
			hsf_pkg::MODE_IDLE:  code_d = hsf_pkg::CODE_IDLE;
			hsf_pkg::MODE_RAMP:  code_d = hsf_pkg::CODE_RAMP;
			hsf_pkg::MODE_TRACK: code_d = hsf_pkg::CODE_TRACK;
			default:             code_d = hsf_pkg::CODE_FAULT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			code_s2     <= code_d;
			near_s2     <= near_now;
			overtemp_s2 <= latch_d;
			heater_s2   <= (mode_d == hsf_pkg::MODE_RAMP) || (mode_d == hsf_pkg::MODE_TRACK);
		end
	end

	assign out_valid  = valid_s2;
	assign state_code = code_s2;
	assign near_limit = near_s2;
	assign overtemp   = overtemp_s2;
	assign heater_on  = heater_s2;

endmodule

[design/hsf_checker.sv]
// ----------------------------------------------------------------------------
// hsf_checker
// Port-level checks for the heater supervision unit, bound to the top level.
// ----------------------------------------------------------------------------
module hsf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [1:0]                    state_code,
	input logic                          near_limit,
	input logic                          overtemp,
	input logic                          heater_on
);

	// A result held back by the receiver keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(state_code) &&
			$stable(overtemp) && $stable(heater_on) && $stable(near_limit))
		else $error("stalled result changed");

	// The heater is permitted exactly in ramp and track.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> heater_on == ((state_code == hsf_pkg::CODE_RAMP) ||
			(state_code == hsf_pkg::CODE_TRACK)))
		else $error("heater permission disagrees with state");

	// The overtemperature latch is set exactly while in fault.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> overtemp == (state_code == hsf_pkg::CODE_FAULT))
		else $error("overtemperature alarm disagrees with state");

	// Nothing comes out of a freshly reset unit.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid right after reset");

endmodule

bind heater_supervision_fsm_unit hsf_checker u_hsf_checker (.*);
